FILE: hdl/bsc_pkg.sv
// Package for the B-spline curve point evaluator.
// Sizes, codes, item types and the FSM state type; used by every bsc_* module.
package bsc_pkg;
    localparam int MAX_DEG    = 7;
    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEG + 1;
    localparam int KIDX_W     = $clog2(KNOT_DEPTH);
    localparam int PIDX_W     = $clog2(MAX_POINTS);
    localparam int DEG_W      = 3;
    localparam int KNOT_W     = 17;
    localparam int COORD_W    = 32;
    localparam int LR_W       = KNOT_W + 1;
    localparam int NB_W       = 33;
    localparam int DVD_W      = 48;
    localparam int PROD_W     = 66;
    localparam int ACC_W      = 56;
    localparam int Q_DEPTH    = 2;

    localparam logic [KNOT_W-1:0] KNOT_ONE = 17'h10000;

    localparam logic [1:0] MODE_KNOT  = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_EVAL  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_CLAMP = 2'd1;
    localparam logic [1:0] STAT_ZERO  = 2'd2;

    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_LAST   = 1'b1;

    typedef enum logic [1:0] {
        K_KNOT,
        K_POINT,
        K_EVAL
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic [6:0]                idx;
        logic [KNOT_W-1:0]         val;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [5:0]                span;
        logic [1:0]                status;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_SRCH,
        ST_SCMP,
        ST_LR_RD,
        ST_LR_WR,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_FIN,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_PT_RD,
        ST_PT_MUL,
        ST_PT_ACC,
        ST_OUT
    } t_state;
endpackage

FILE: hdl/bspline_curve_point_eval.sv
// B-spline curve point evaluator, top level.
// Holds the configuration registers and joins front end, queue and engine.
// Depends on bsc_pkg, bsc_front, bsc_fifo and bsc_back.
//
// Use: the s_axis channel carries requests, tuser holds the mode. Mode 0 writes
// a knot, mode 1 a control point, mode 2 evaluates the curve at param_u; mode 3
// is dropped. Only evaluate requests give a result on m_axis. The cfg channel
// writes degree (index 0) and last_point_index (index 1); it is always ready
// and must be written only while the block is idle; the block does not enforce it.
// Requests pass a two-entry queue, so the input keeps accepting while the
// engine works, until the queue is full. Write requests are stored as they
// leave the queue. An evaluate is dominated by the one-bit-per-cycle
// divider, 48 steps for each basis term; a zero denominator term skips it.
// The result sits in an output register; while m_axis_tready is low the
// engine holds its finished result and the queue fills behind it.
// Reset: degree and last_point_index return to 3, queue and output empty;
// knot and point memories are not cleared and must be written before use.
module bspline_curve_point_eval (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    // entry_index[6:0], knot_value[23:7], point_x[55:24], point_y[87:56],
    // point_z[119:88], param_u[136:120], zero fill [143:137]
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // curve_x[31:0], curve_y[63:32], curve_z[95:64], span_found[101:96],
    // status[103:102]
    output logic [103:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [5:0]   i_cfg_data
);
    import bsc_pkg::*;

    logic [2:0]  r_degree;
    logic [5:0]  r_last;
    logic        w_push, w_pop;
    t_item       w_fitem, w_qitem;
    t_qstat      w_qstat;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'd3;
            r_last   <= 6'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEGREE: r_degree <= i_cfg_data[2:0];
                REG_LAST:   r_last   <= i_cfg_data;
                default:    r_last   <= r_last;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    bsc_front u_front (
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .i_idx   (s_axis_tdata[6:0]),
        .i_knot  (s_axis_tdata[23:7]),
        .i_x     (s_axis_tdata[55:24]),
        .i_y     (s_axis_tdata[87:56]),
        .i_z     (s_axis_tdata[119:88]),
        .i_u     (s_axis_tdata[136:120]),
        .i_qstat (w_qstat),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_item  (w_fitem)
    );

    bsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_item  (w_qitem),
        .o_qstat (w_qstat)
    );

    bsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_degree    (r_degree),
        .i_last      (r_last),
        .i_item      (w_qitem),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .i_res_ready (m_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {w_res.status, w_res.span, w_res.z, w_res.y, w_res.x};

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[103:102] != 2'd3))
        else $error("undefined status code");

    a_span_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[101:96] >= 6'(r_degree)))
        else $error("span below degree");

    a_span_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[101:96] <= r_last
                           || m_axis_tdata[101:96] == 6'(r_degree)))
        else $error("span above last point");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");
endmodule

FILE: hdl/bsc_front.sv
// Front end: decodes the mode of each input request and prepares the queue entry.
// Depends on bsc_pkg.
module bsc_front (
    input  logic              i_valid,
    input  logic [1:0]        i_mode,
    input  logic [6:0]        i_idx,
    input  logic [16:0]       i_knot,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic [16:0]       i_u,
    input  bsc_pkg::t_qstat   i_qstat,
    output logic              o_ready,
    output logic              o_push,
    output bsc_pkg::t_item    o_item
);
    import bsc_pkg::*;

    logic w_keep;

    always_comb begin
        o_item.idx = i_idx;
        o_item.x   = i_x;
        o_item.y   = i_y;
        o_item.z   = i_z;
        w_keep     = 1'b1;
        case (i_mode)
            MODE_KNOT: begin
                o_item.kind = K_KNOT;
                o_item.val  = (i_knot > KNOT_ONE) ? KNOT_ONE : i_knot;
            end
            MODE_POINT: begin
                o_item.kind = K_POINT;
                o_item.val  = i_u;
            end
            MODE_EVAL: begin
                o_item.kind = K_EVAL;
                o_item.val  = i_u;
            end
            default: begin
                o_item.kind = K_EVAL;
                o_item.val  = i_u;
                w_keep      = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && o_ready && w_keep;
endmodule

FILE: hdl/bsc_fifo.sv
// Two-entry queue between front end and evaluation engine.
// Depends on bsc_pkg.
module bsc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsc_pkg::t_item  i_item,
    input  logic            i_pop,
    output bsc_pkg::t_item  o_item,
    output bsc_pkg::t_qstat o_qstat
);
    import bsc_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_item           r_mem [0:Q_DEPTH-1];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    assign o_item        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
endmodule

FILE: hdl/bsc_back.sv
// Evaluation engine: knot and point memories, span search, Cox-de Boor basis
// with a serial divider, weighted point sum and the result register. Uses bsc_pkg.
module bsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_degree,
    input  logic [5:0]          i_last,
    input  bsc_pkg::t_item      i_item,
    input  bsc_pkg::t_qstat     i_qstat,
    output logic                o_pop,
    input  logic                i_res_ready,
    output logic                o_res_valid,
    output bsc_pkg::t_result    o_res
);
    import bsc_pkg::*;

    localparam logic signed [PROD_W-1:0] BLIM = PROD_W'(64'sd1 <<< 31);
    localparam int CNT_W = $clog2(DVD_W);

    t_state r_state, n_state;

    logic [KNOT_W-1:0]         r_kmem [0:KNOT_DEPTH-1];
    logic signed [COORD_W-1:0] r_xmem [0:MAX_POINTS-1];
    logic signed [COORD_W-1:0] r_ymem [0:MAX_POINTS-1];
    logic signed [COORD_W-1:0] r_zmem [0:MAX_POINTS-1];
    logic [KNOT_W-1:0]         r_kdata;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;

    logic [KNOT_W-1:0]         r_u, r_lo;
    logic [KIDX_W-1:0]         r_low, r_high;
    logic [5:0]                r_span;
    logic [DEG_W-1:0]          r_j, r_r, r_i;
    logic                      r_side;
    logic signed [LR_W-1:0]    r_left  [0:MAX_DEG];
    logic signed [LR_W-1:0]    r_right [0:MAX_DEG];
    logic signed [NB_W-1:0]    r_nb    [0:MAX_DEG];
    logic signed [NB_W-1:0]    r_saved, r_t;
    logic [LR_W-1:0]           r_rem, r_dvs;
    logic [DVD_W-1:0]          r_dvd, r_q;
    logic                      r_neg;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [PROD_W-1:0]  r_prod, r_px, r_py, r_pz;
    logic signed [ACC_W-1:0]   r_sx, r_sy, r_sz;
    logic [1:0]                r_stat;
    logic                      r_zero;
    logic                      r_vld;
    t_result                   r_res;

    logic [DEG_W-1:0]          w_p;
    logic [5:0]                w_n;
    logic [KIDX_W-1:0]         w_np1, w_kaddr, w_mid, w_nlow, w_nhigh;
    logic [KIDX_W:0]           w_sum;
    logic [PIDX_W-1:0]         w_paddr;
    logic [KNOT_W-1:0]         w_uc;
    logic                      w_uclamp, w_ueq, w_hi_done, w_less, w_sdone;
    logic signed [LR_W:0]      w_den;
    logic [LR_W:0]             w_trial;
    logic [NB_W-1:0]           w_qmag;
    logic signed [NB_W-1:0]    w_nbmag, w_sv;
    logic                      w_wr_k, w_wr_p, w_load;

    function automatic logic signed [PROD_W-1:0] f_tdz(
        input logic signed [PROD_W-1:0] a,
        input int sh
    );
        logic signed [PROD_W-1:0] bias;
        bias = a[PROD_W-1] ? ((PROD_W'(1) <<< sh) - PROD_W'(1)) : '0;
        return (a + bias) >>> sh;
    endfunction

    function automatic logic signed [NB_W-1:0] f_clamp(input logic signed [PROD_W-1:0] a);
        logic signed [NB_W-1:0] res;
        if (a > BLIM) begin
            res = NB_W'(BLIM);
        end else if (a < -BLIM) begin
            res = NB_W'(-BLIM);
        end else begin
            res = a[NB_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] f_sat(input logic signed [ACC_W-1:0] a);
        logic signed [COORD_W-1:0] res;
        if (a > ACC_W'(64'sh7FFFFFFF)) begin
            res = 32'sh7FFFFFFF;
        end else if (a < -ACC_W'(64'sh80000000)) begin
            res = 32'sh80000000;
        end else begin
            res = a[COORD_W-1:0];
        end
        return res;
    endfunction

    // configuration limits
    always_comb begin
        w_p   = (i_degree > DEG_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : i_degree;
        w_n   = (i_last < 6'(w_p)) ? 6'(w_p) : i_last;
        w_np1 = KIDX_W'(w_n) + 1'b1;
    end

    // span search helpers
    always_comb begin
        w_uclamp = 1'b0;
        w_uc     = r_u;
        if (r_u < r_lo) begin
            w_uc = r_lo;
            w_uclamp = 1'b1;
        end else if (r_u > r_kdata) begin
            w_uc = r_kdata;
            w_uclamp = 1'b1;
        end
        w_ueq     = (w_uc == r_kdata);
        w_hi_done = w_ueq || ((w_np1 - KIDX_W'(w_p)) <= KIDX_W'(1));
        w_sum     = {1'b0, r_low} + {1'b0, r_high};
        w_mid     = w_sum[KIDX_W:1];
        w_less    = r_u < r_kdata;
        w_nlow    = w_less ? r_low : w_mid;
        w_nhigh   = w_less ? w_mid : r_high;
        w_sdone   = (w_nhigh - w_nlow) <= KIDX_W'(1);
    end

    // recurrence helpers
    always_comb begin
        w_den   = (LR_W+1)'(r_right[r_r + 1'b1]) + (LR_W+1)'(r_left[r_j - r_r]);
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_qmag  = (r_q > DVD_W'(BLIM)) ? NB_W'(BLIM) : r_q[NB_W-1:0];
        w_nbmag = r_nb[r_r][NB_W-1] ? -r_nb[r_r] : r_nb[r_r];
        w_sv    = f_clamp(f_tdz(r_prod, 16));
    end

    // addresses, pops, writes
    always_comb begin
        w_kaddr = KIDX_W'(w_p);
        case (r_state)
            ST_LO:    w_kaddr = w_np1;
            ST_SRCH:  w_kaddr = w_mid;
            ST_LR_RD: w_kaddr = r_side ? (KIDX_W'(r_span) + KIDX_W'(r_j))
                                       : (KIDX_W'(r_span) + 1'b1 - KIDX_W'(r_j));
            default:  w_kaddr = KIDX_W'(w_p);
        endcase
        w_paddr = r_span - PIDX_W'(w_p) + PIDX_W'(r_i);
        o_pop   = (r_state == ST_IDLE) && !i_qstat.empty;
        w_wr_k  = o_pop && (i_item.kind == K_KNOT) && (i_item.idx < 7'(KNOT_DEPTH));
        w_wr_p  = o_pop && (i_item.kind == K_POINT) && (i_item.idx < 7'(MAX_POINTS));
        w_load  = (r_state == ST_OUT) && (!r_vld || i_res_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (o_pop && i_item.kind == K_EVAL) n_state = ST_LO;
            ST_LO:       n_state = ST_HI;
            ST_HI: begin
                if (!w_hi_done) n_state = ST_SRCH;
                else if (w_p == '0) n_state = ST_PT_RD;
                else n_state = ST_LR_RD;
            end
            ST_SRCH:     n_state = ST_SCMP;
            ST_SCMP: begin
                if (!w_sdone) n_state = ST_SRCH;
                else if (w_p == '0) n_state = ST_PT_RD;
                else n_state = ST_LR_RD;
            end
            ST_LR_RD:    n_state = ST_LR_WR;
            ST_LR_WR:    n_state = (r_side && r_j == w_p) ? ST_DIV_INIT : ST_LR_RD;
            ST_DIV_INIT: n_state = (w_den == '0) ? ST_MUL1 : ST_DIV;
            ST_DIV:      if (r_cnt == CNT_W'(DVD_W-1)) n_state = ST_DIV_FIN;
            ST_DIV_FIN:  n_state = ST_MUL1;
            ST_MUL1:     n_state = ST_MUL2;
            ST_MUL2:     n_state = ST_MUL3;
            ST_MUL3: begin
                if (r_r == r_j - 1'b1 && r_j == w_p) n_state = ST_PT_RD;
                else n_state = ST_DIV_INIT;
            end
            ST_PT_RD:    n_state = ST_PT_MUL;
            ST_PT_MUL:   n_state = ST_PT_ACC;
            ST_PT_ACC:   n_state = (r_i == w_p) ? ST_OUT : ST_PT_RD;
            ST_OUT:      if (w_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_wr_k) begin
            r_kmem[i_item.idx[KIDX_W-1:0]] <= i_item.val;
        end
        r_kdata <= r_kmem[w_kaddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_p) begin
            r_xmem[i_item.idx[PIDX_W-1:0]] <= i_item.x;
            r_ymem[i_item.idx[PIDX_W-1:0]] <= i_item.y;
            r_zmem[i_item.idx[PIDX_W-1:0]] <= i_item.z;
        end
        r_cx <= r_xmem[w_paddr];
        r_cy <= r_ymem[w_paddr];
        r_cz <= r_zmem[w_paddr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_u     <= i_item.val;
                r_nb[0] <= NB_W'(64'sd1 <<< FRAC_BITS);
                r_stat  <= STAT_OK;
                r_zero  <= 1'b0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sz    <= '0;
                r_i     <= '0;
                r_j     <= DEG_W'(1);
                r_r     <= '0;
                r_side  <= 1'b0;
                r_saved <= '0;
            end
            ST_LO: r_lo <= r_kdata;
            ST_HI: begin
                r_u    <= w_uc;
                r_stat <= w_uclamp ? STAT_CLAMP : STAT_OK;
                r_low  <= KIDX_W'(w_p);
                r_high <= w_np1;
                r_span <= w_ueq ? w_n : 6'(w_p);
            end
            ST_SCMP: begin
                r_low  <= w_nlow;
                r_high <= w_nhigh;
                r_span <= w_nlow[5:0];
            end
            ST_LR_WR: begin
                if (r_side) begin
                    r_right[r_j] <= LR_W'(r_kdata) - LR_W'(r_u);
                    r_j <= (r_j == w_p) ? DEG_W'(1) : r_j + 1'b1;
                end else begin
                    r_left[r_j] <= LR_W'(r_u) - LR_W'(r_kdata);
                end
                r_side <= !r_side;
            end
            ST_DIV_INIT: begin
                if (w_den == '0) begin
                    r_t    <= '0;
                    r_zero <= 1'b1;
                end
                r_dvd <= {w_nbmag[NB_W-2:0], 16'b0};
                r_dvs <= w_den[LR_W] ? LR_W'(-w_den) : LR_W'(w_den);
                r_neg <= r_nb[r_r][NB_W-1] ^ w_den[LR_W];
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                if (w_trial >= {1'b0, r_dvs}) begin
                    r_rem <= LR_W'(w_trial - {1'b0, r_dvs});
                    r_q   <= {r_q[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= LR_W'(w_trial);
                    r_q   <= {r_q[DVD_W-2:0], 1'b0};
                end
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_DIV_FIN: r_t <= r_neg ? -$signed(w_qmag) : $signed(w_qmag);
            ST_MUL1: r_prod <= PROD_W'(r_right[r_r + 1'b1]) * PROD_W'(r_t);
            ST_MUL2: begin
                r_nb[r_r] <= f_clamp(PROD_W'(r_saved) + f_tdz(r_prod, 16));
                r_prod    <= PROD_W'(r_left[r_j - r_r]) * PROD_W'(r_t);
            end
            ST_MUL3: begin
                if (r_r == r_j - 1'b1) begin
                    r_nb[r_j] <= w_sv;
                    r_saved   <= '0;
                    r_r       <= '0;
                    r_j       <= r_j + 1'b1;
                end else begin
                    r_saved <= w_sv;
                    r_r     <= r_r + 1'b1;
                end
            end
            ST_PT_MUL: begin
                r_px <= PROD_W'(r_nb[r_i]) * PROD_W'(r_cx);
                r_py <= PROD_W'(r_nb[r_i]) * PROD_W'(r_cy);
                r_pz <= PROD_W'(r_nb[r_i]) * PROD_W'(r_cz);
            end
            ST_PT_ACC: begin
                r_sx <= r_sx + ACC_W'(f_tdz(r_px, FRAC_BITS));
                r_sy <= r_sy + ACC_W'(f_tdz(r_py, FRAC_BITS));
                r_sz <= r_sz + ACC_W'(f_tdz(r_pz, FRAC_BITS));
                r_i  <= r_i + 1'b1;
            end
            ST_OUT: begin
                if (w_load) begin
                    r_res.x      <= f_sat(r_sx);
                    r_res.y      <= f_sat(r_sy);
                    r_res.z      <= f_sat(r_sz);
                    r_res.span   <= r_span;
                    r_res.status <= r_zero ? STAT_ZERO : r_stat;
                end
            end
            default: ;
        endcase
    end

    assign o_res_valid = r_vld;
    assign o_res       = r_res;
endmodule

FILE: sim/bspline_curve_point_eval_tb.sv
// Testbench for bspline_curve_point_eval: loads knots and control points,
// evaluates the curve and checks each result against a built-in predictor.
// Depends on bsc_pkg and the bspline_curve_point_eval RTL.
module bspline_curve_point_eval_tb;
    import bsc_pkg::*;

    typedef struct {
        logic [1:0]  mode;
        logic [6:0]  idx;
        logic [16:0] kval;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [16:0] u;
        bit          has_exp;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic [5:0]  espan;
        logic [1:0]  estat;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser = '0;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = 1'b0;
    logic [5:0]   i_cfg_data = '0;

    bspline_curve_point_eval i_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    int unsigned pdeg = 3;
    int unsigned plast = 3;
    longint knots[KNOT_DEPTH];
    longint cx[MAX_POINTS];
    longint cy[MAX_POINTS];
    longint cz[MAX_POINTS];

    logic [103:0] curve_q[$];
    int           errors = 0;
    longint       cycles = 0;
    logic         rx_hold = 1'b0;

    function automatic longint clampb(longint v);
        if (v > (64'sd1 <<< 31)) return 64'sd1 <<< 31;
        if (v < -(64'sd1 <<< 31)) return -(64'sd1 <<< 31);
        return v;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint kat(int unsigned i);
        return i < KNOT_DEPTH ? knots[i] : 0;
    endfunction

    // updates stores; returns 1 with the packed curve point for evaluate requests
    function automatic bit predict_curve(t_row r, output logic [103:0] res);
        int unsigned p, n, lo_i, hi_i, span, stat, mid, k;
        longint u, lo, hi, den, t, saved, sx, sy, sz;
        longint nb[MAX_DEG+1];
        longint lf[MAX_DEG+1];
        longint rt[MAX_DEG+1];
        bit zd;
        res = '0;
        if (r.mode == MODE_KNOT) begin
            if (r.idx < KNOT_DEPTH) knots[r.idx] = r.kval > KNOT_ONE ? KNOT_ONE : r.kval;
            return 0;
        end
        if (r.mode == MODE_POINT) begin
            if (r.idx < MAX_POINTS) begin
                cx[r.idx] = $signed(r.px);
                cy[r.idx] = $signed(r.py);
                cz[r.idx] = $signed(r.pz);
            end
            return 0;
        end
        if (r.mode != MODE_EVAL) return 0;
        p = pdeg; n = plast;
        if (n < p) n = p;
        stat = STAT_OK; zd = 0;
        u = r.u; lo = kat(p); hi = kat(n + 1);
        if (u < lo) begin u = lo; stat = STAT_CLAMP; end
        else if (u > hi) begin u = hi; stat = STAT_CLAMP; end
        if (u == hi) span = n;
        else begin
            lo_i = p; hi_i = n + 1;
            while (hi_i - lo_i > 1) begin
                mid = (lo_i + hi_i) / 2;
                if (u < kat(mid)) hi_i = mid;
                else lo_i = mid;
            end
            span = lo_i;
        end
        nb[0] = 64'sd1 <<< FRAC_BITS;
        for (int j = 1; j <= p; j++) begin
            saved = 0;
            lf[j] = u - kat(span + 1 - j);
            rt[j] = kat(span + j) - u;
            for (int q = 0; q < j; q++) begin
                den = rt[q+1] + lf[j-q];
                if (den == 0) begin t = 0; zd = 1; end
                else t = clampb((nb[q] * 65536) / den);
                nb[q] = clampb(saved + (rt[q+1] * t) / 65536);
                saved = clampb((lf[j-q] * t) / 65536);
            end
            nb[j] = saved;
        end
        sx = 0; sy = 0; sz = 0;
        for (int i = 0; i <= p; i++) begin
            k = span - p + i;
            if (k < MAX_POINTS) begin
                sx += (nb[i] * cx[k]) / 65536;
                sy += (nb[i] * cy[k]) / 65536;
                sz += (nb[i] * cz[k]) / 65536;
            end
        end
        if (zd) stat = STAT_ZERO;
        res = {stat[1:0], span[5:0], sat32(sz), sat32(sy), sat32(sx)};
        return 1;
    endfunction

    function automatic logic [143:0] pack_req(t_row r);
        return {7'd0, r.u, r.pz, r.py, r.px, r.kval, r.idx};
    endfunction

    function automatic t_row mk(logic [1:0] m, logic [6:0] i, logic [16:0] kv,
                                logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [16:0] u);
        t_row r;
        r.mode = m; r.idx = i; r.kval = kv; r.px = x; r.py = y; r.pz = z; r.u = u;
        r.has_exp = 0; r.ex = 0; r.ey = 0; r.ez = 0; r.espan = 0; r.estat = 0;
        return r;
    endfunction

    // 0 none, 1 sender 88%, 2 receiver 88%, 3 both 37%
    int idle_mode = 0;

    // tvalid stays high between back-to-back requests; drain() drops it
    task automatic send_req(t_row r);
        logic [103:0] res;
        if (idle_mode == 1 || idle_mode == 3) begin
            while ($urandom_range(99) < (idle_mode == 1 ? 88 : 37)) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.mode;
        s_axis_tdata <= pack_req(r);
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_curve(r, res)) begin
            if (r.has_exp && res !== {r.estat, r.espan, r.ez, r.ey, r.ex}) begin
                $error("table row disagrees with predictor: %h vs %h", res,
                       {r.estat, r.espan, r.ez, r.ey, r.ex});
                errors++;
            end
            curve_q.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else if (idle_mode == 2 || idle_mode == 3)
            m_axis_tready <= $urandom_range(99) >= (idle_mode == 2 ? 88 : 37);
        else
            m_axis_tready <= 1'b1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (curve_q.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                logic [103:0] e;
                e = curve_q.pop_front();
                if (e[31:0] !== m_axis_tdata[31:0]) begin
                    $error("curve_x exp %h got %h", e[31:0], m_axis_tdata[31:0]); errors++;
                end
                if (e[63:32] !== m_axis_tdata[63:32]) begin
                    $error("curve_y exp %h got %h", e[63:32], m_axis_tdata[63:32]); errors++;
                end
                if (e[95:64] !== m_axis_tdata[95:64]) begin
                    $error("curve_z exp %h got %h", e[95:64], m_axis_tdata[95:64]); errors++;
                end
                if (e[101:96] !== m_axis_tdata[101:96]) begin
                    $error("span_found exp %0d got %0d", e[101:96], m_axis_tdata[101:96]);
                    errors++;
                end
                if (e[103:102] !== m_axis_tdata[103:102]) begin
                    $error("status exp %0d got %0d", e[103:102], m_axis_tdata[103:102]);
                    errors++;
                end
            end
        end
        if (cycles > 20000000) begin
            $display("[bspline_curve_point_eval] ERROR");
            $finish;
        end
    end

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (curve_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [5:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_DEGREE) pdeg = v[2:0];
        else plast = v;
    endtask

    // loads a clamped, ordered knot vector and random points for (p, n)
    task automatic load_curve(int unsigned p, int unsigned n, bit dup);
        logic [16:0] kv, prev;
        prev = 0;
        for (int i = 0; i <= n + p + 1; i++) begin
            if (i <= p) kv = 0;
            else if (i > n) kv = KNOT_ONE;
            else begin
                kv = 17'(prev + $urandom_range(0, (KNOT_ONE - prev) / (n - i + 2)));
                if (!dup && kv == prev) kv = prev + 1'b1;
            end
            prev = kv;
            send_req(mk(MODE_KNOT, 7'(i), kv, 0, 0, 0, 0));
        end
        for (int i = 0; i <= n; i++)
            send_req(mk(MODE_POINT, 7'(i), 0, $urandom, $urandom, $urandom, 0));
    endtask

    t_row dir[$];
    t_row r;
    int unsigned pp, nn, sent;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config p=3, n=3; clamped knots, identical points (x = 1.0, y and z at the 32-bit extremes)
        for (int i = 0; i < 8; i++) dir.push_back(mk(MODE_KNOT, 7'(i),
                                                     i < 4 ? 17'd0 : 17'h1FFFF,
                                                     0, 0, 0, 0));
        dir.push_back(mk(MODE_POINT, 0, 0, 32'h00010000, 32'h80000000, 32'h7FFFFFFF, 0));
        dir.push_back(mk(MODE_POINT, 1, 0, 32'h00010000, 32'h80000000, 32'h7FFFFFFF, 0));
        dir.push_back(mk(MODE_POINT, 2, 0, 32'h00010000, 32'h80000000, 32'h7FFFFFFF, 0));
        dir.push_back(mk(MODE_POINT, 3, 0, 32'h00010000, 32'h80000000, 32'h7FFFFFFF, 0));
        dir.push_back(mk(MODE_POINT, 127, 0, 32'hFFFFFFFF, 0, 0, 0));
        dir.push_back(mk(MODE_KNOT, 127, 17'h1FFFF, 0, 0, 0, 0));
        dir.push_back(mk(2'd3, 127, 17'h1FFFF, '1, '1, '1, 17'h1FFFF));
        r = mk(MODE_EVAL, 0, 0, 0, 0, 0, 0);
        r.has_exp = 1; r.ex = 32'h00010000; r.ey = 32'h80000000; r.ez = 32'h7FFFFFFF;
        r.espan = 3; r.estat = STAT_OK;
        dir.push_back(r);
        r.u = 17'h10000; dir.push_back(r);
        r.u = 17'h1FFFF; r.estat = STAT_CLAMP; dir.push_back(r);
        dir.push_back(mk(MODE_EVAL, 0, 0, 0, 0, 0, 17'h08000));
        // collapsed interior: zero denominators
        dir.push_back(mk(MODE_KNOT, 4, 0, 0, 0, 0, 0));
        dir.push_back(mk(MODE_KNOT, 5, 0, 0, 0, 0, 0));
        dir.push_back(mk(MODE_EVAL, 0, 0, 0, 0, 0, 17'h04000));
        foreach (dir[i]) send_req(dir[i]);
        drain();

        // degree 1, extremes of n
        write_cfg(REG_DEGREE, 1);
        write_cfg(REG_LAST, 63);
        load_curve(1, 63, 1);
        for (int i = 0; i < 20; i++) send_req(mk(MODE_EVAL, 0, 0, 0, 0, 0, 17'($urandom)));
        drain();
        write_cfg(REG_LAST, 1);
        load_curve(1, 1, 0);
        for (int i = 0; i < 10; i++) send_req(mk(MODE_EVAL, 0, 0, 0, 0, 0, 17'($urandom)));
        drain();

        // long receiver hold-off while requests keep coming
        fork
            begin
                rx_hold = 1'b1;
                repeat (4000) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 8; i++)
                    send_req(mk(MODE_EVAL, 0, 0, 0, 0, 0, 17'($urandom)));
            end
        join
        drain();

        sent = 0;
        for (int ph = 0; sent < 1900; ph++) begin
            idle_mode = ph % 4;
            pp = ph % 9 == 0 ? 7 : (ph % 9 == 1 ? 6 : $urandom_range(1, 4));
            nn = ph % 7 == 0 ? $urandom_range(pp, 63) : $urandom_range(pp, pp + 6);
            if (ph % 5 == 4) nn = $urandom_range(0, pp);
            write_cfg(REG_DEGREE, 6'(pp));
            write_cfg(REG_LAST, 6'(nn));
            if (nn < pp) nn = pp;
            load_curve(pp, nn, ph % 3 == 0);
            sent += 2 * nn + pp + 3;
            for (int i = 0; i < 40; i++) begin
                case ($urandom_range(9))
                    0: send_req(mk(MODE_KNOT, 7'($urandom_range(80, 127)), 17'($urandom),
                                   0, 0, 0, 0));
                    1: send_req(mk(MODE_POINT, 7'($urandom_range(64, 127)), 0,
                                   $urandom, $urandom, $urandom, 0));
                    2: send_req(mk(2'd3, 7'($urandom), 17'($urandom), $urandom, $urandom,
                                   $urandom, 17'($urandom)));
                    3: send_req(mk(MODE_POINT, 7'($urandom_range(0, nn)), 0,
                                   $urandom, $urandom, $urandom, 0));
                    default: send_req(mk(MODE_EVAL, 7'($urandom), 17'($urandom), $urandom,
                                         $urandom, $urandom, 17'($urandom)));
                endcase
            end
            sent += 40;
            drain();
        end
        write_cfg(REG_DEGREE, 3);
        write_cfg(REG_LAST, 3);
        drain();

        if (errors == 0)
            $display("[bspline_curve_point_eval] OK");
        else
            $display("[bspline_curve_point_eval] ERROR");
        $finish;
    end
endmodule
